>>> rtl/sacl_pkg.sv
// sacl_pkg: shared types and constants of the set-associative cache lookup.
// No dependencies; imported by both RTL modules, the checker and tb.
package sacl_pkg;

	// sequencer states of the top level
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_RD,
		ST_CMP,
		ST_WR
	} state_t;

	// replacement policy codes
	localparam logic POLICY_LFU = 1'b0;
	localparam logic POLICY_LRU = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_POLICY       = 3'd0;
	localparam logic [2:0] CFG_OFFSET_BITS  = 3'd1;
	localparam logic [2:0] CFG_INDEX_BITS   = 3'd2;
	localparam logic [2:0] CFG_WAYS_IN_USE  = 3'd3;
	localparam logic [2:0] CFG_HIT_TIME     = 3'd4;
	localparam logic [2:0] CFG_MISS_PENALTY = 3'd5;

	// masked set index before the reduction modulo the set count
	localparam int IDX_RAW_W = 15;

	localparam logic [15:0] USE_MAX = 16'hFFFF;
	localparam logic [31:0] TOT_MAX = 32'hFFFF_FFFF;

endpackage

>>> rtl/set_assoc_cache_lru_lfu_lookup.sv
// set_assoc_cache_lru_lfu_lookup: top level of the LRU/LFU cache lookup.
// Depends on sacl_pkg and sacl_set_mod.
// Items are taken one at a time: the next address waits until the last result is loaded,
// and a stalled result holds off both that load and the next address. Ways are read
// up to the hit, else ways_in_use, by one shared tag/metric compare, one way at a time
// through registered reads; a set count that is not a power of two adds a set remainder
// step first. Reset: control clears at once, then a clearing pass over all SETS*WAYS
// lines (2048 at the defaults) zeroes valid bits and metrics; no item is taken meanwhile.
module set_assoc_cache_lru_lfu_lookup
	import sacl_pkg::*;
#(
	parameter int SETS          = 256,
	parameter int WAYS          = 8,
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input item channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ADDRESS_WIDTH-1:0] address,
	// result item channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [2:0]               way,
	output logic [31:0]              miss_total,
	output logic [31:0]              cycle_total,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data
);

	localparam int   LINES     = SETS * WAYS;
	localparam int   LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int   SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int   WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic SETS_POW2 = ((SETS & (SETS - 1)) == 0);

	// ---------------------------------------------------------------- config
	logic        policy_q;
	logic [4:0]  offset_bits_q;
	logic [3:0]  index_bits_q;
	logic [3:0]  ways_in_use_q;
	logic [7:0]  hit_time_q;
	logic [15:0] miss_penalty_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q       <= POLICY_LRU;
			offset_bits_q  <= 5'd4;
			index_bits_q   <= 4'd8;
			ways_in_use_q  <= 4'd8;
			hit_time_q     <= 8'd1;
			miss_penalty_q <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POLICY:       policy_q       <= cfg_data[0];
				CFG_OFFSET_BITS:  offset_bits_q  <= cfg_data[4:0];
				CFG_INDEX_BITS:   index_bits_q   <= cfg_data[3:0];
				CFG_WAYS_IN_USE:  ways_in_use_q  <= cfg_data[3:0];
				CFG_HIT_TIME:     hit_time_q     <= cfg_data[7:0];
				CFG_MISS_PENALTY: miss_penalty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic lfu;
	assign lfu = (policy_q == POLICY_LFU);

	// last way scanned: ways_in_use clamped to 1..WAYS, minus one
	logic [4:0]       nw_clamp;
	logic [4:0]       nw_minus1;
	logic [WAY_W-1:0] nways_last;
	always_comb begin
		if (ways_in_use_q == 4'd0) begin
			nw_clamp = 5'd1;
		end else if (5'(ways_in_use_q) > 5'(WAYS)) begin
			nw_clamp = 5'(WAYS);
		end else begin
			nw_clamp = 5'(ways_in_use_q);
		end
		nw_minus1  = nw_clamp - 5'd1;
		nways_last = nw_minus1[WAY_W-1:0];
	end

	// ---------------------------------------------------------- address split
	logic [31:0]          addr32;
	logic [31:0]          addr_sh;
	logic [15:0]          idx_mask16;
	logic [IDX_RAW_W-1:0] idx_raw;
	logic [5:0]           tshift;
	logic [31:0]          tag_full;
	logic [ADDRESS_WIDTH-1:0] tag_in;

	always_comb begin
		addr32     = 32'(address);
		addr_sh    = addr32 >> offset_bits_q;
		idx_mask16 = (16'd1 << index_bits_q) - 16'd1;
		idx_raw    = addr_sh[IDX_RAW_W-1:0] & idx_mask16[IDX_RAW_W-1:0];
		tshift     = 6'(offset_bits_q) + 6'(index_bits_q);
		// tag vanishes when offset and index cover the whole word
		tag_full   = (tshift >= 6'd32) ? 32'd0 : (addr32 >> tshift[4:0]);
		tag_in     = tag_full[ADDRESS_WIDTH-1:0];
	end

	// ---------------------------------------------------------- sequencer
	state_t st_q, st_d;

	logic                     accept;
	logic                     mod_start;
	logic                     mod_done;
	logic [SET_W-1:0]         mod_rem;
	logic [SET_W-1:0]         set_q;
	logic [ADDRESS_WIDTH-1:0] tag_q;
	logic [WAY_W-1:0]         way_idx_q;
	logic [WAY_W-1:0]         victim_q;
	logic [31:0]              best_q;
	logic                     hit_q;
	logic [15:0]              hit_cnt_q;
	logic [LINE_W-1:0]        clr_q;
	logic [31:0]              atime_q;
	logic [31:0]              miss_q;
	logic [31:0]              cyc_q;

	// registered read of the way under compare
	logic                     rd_vld_q;
	logic [ADDRESS_WIDTH-1:0] rd_tag_q;
	logic [15:0]              rd_cnt_q;
	logic [31:0]              rd_tim_q;

	logic                     out_valid_q;
	logic                     out_hit_q;
	logic [2:0]               out_way_q;
	logic [31:0]              out_miss_q;
	logic [31:0]              out_cyc_q;

	logic                     rd_en;
	logic                     finish;
	logic                     we_vld, we_tag, we_cnt, we_tim;
	logic [LINE_W-1:0]        wr_addr;
	logic [LINE_W-1:0]        rd_addr;
	logic                     wr_vld;
	logic [15:0]              wr_cnt;
	logic [31:0]              wr_tim;
	logic [WAY_W-1:0]         tgt_way;
	logic                     match;
	logic [31:0]              metric;
	logic [31:0]              miss_new;
	logic [16:0]              cyc_add;
	logic [32:0]              cyc_sum;
	logic [31:0]              cyc_new;
	logic [WAY_W+2:0]         way_ext;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE);

	assign match   = rd_vld_q && (rd_tag_q == tag_q);
	assign metric  = lfu ? 32'(rd_cnt_q) : rd_tim_q;
	assign tgt_way = hit_q ? way_idx_q : victim_q;
	assign rd_addr = LINE_W'(set_q) * LINE_W'(WAYS) + LINE_W'(way_idx_q);

	// running totals after this item
	always_comb begin
		miss_new = (hit_q || miss_q == TOT_MAX) ? miss_q : miss_q + 32'd1;
		cyc_add  = hit_q ? 17'(hit_time_q) : 17'(hit_time_q) + 17'(miss_penalty_q);
		cyc_sum  = 33'(cyc_q) + 33'(cyc_add);
		cyc_new  = cyc_sum[32] ? TOT_MAX : cyc_sum[31:0];
		way_ext  = {3'b000, tgt_way};
	end

	always_comb begin
		st_d      = st_q;
		rd_en     = 1'b0;
		mod_start = 1'b0;
		finish    = 1'b0;
		we_vld    = 1'b0;
		we_tag    = 1'b0;
		we_cnt    = 1'b0;
		we_tim    = 1'b0;
		wr_addr   = clr_q;
		wr_vld    = 1'b0;
		wr_cnt    = 16'd0;
		wr_tim    = 32'd0;
		unique case (st_q)
			ST_CLEAR: begin
				we_vld = 1'b1;
				we_cnt = 1'b1;
				we_tim = 1'b1;
				if (clr_q == LINE_W'(LINES - 1)) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (SETS_POW2) begin
						st_d = ST_RD;
					end else begin
						mod_start = 1'b1;
						st_d      = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (mod_done) st_d = ST_RD;
			end
			ST_RD: begin
				rd_en = 1'b1;
				st_d  = ST_CMP;
			end
			ST_CMP: begin
				if (match || way_idx_q == nways_last) begin
					st_d = ST_WR;
				end else begin
					st_d = ST_RD;
				end
			end
			ST_WR: begin
				// write-back and result load wait for a free output register
				if (!out_valid_q || !out_stall) begin
					finish  = 1'b1;
					st_d    = ST_IDLE;
					wr_addr = LINE_W'(set_q) * LINE_W'(WAYS) + LINE_W'(tgt_way);
					if (hit_q) begin
						if (lfu) begin
							we_cnt = 1'b1;
							wr_cnt = (hit_cnt_q == USE_MAX) ? hit_cnt_q : hit_cnt_q + 16'd1;
						end else begin
							we_tim = 1'b1;
							wr_tim = atime_q;
						end
					end else begin
						we_vld = 1'b1;
						wr_vld = 1'b1;
						we_tag = 1'b1;
						if (lfu) begin
							we_cnt = 1'b1;
							wr_cnt = 16'd1;
						end else begin
							we_tim = 1'b1;
							wr_tim = atime_q;
						end
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			set_q       <= '0;
			tag_q       <= '0;
			way_idx_q   <= '0;
			victim_q    <= '0;
			best_q      <= '0;
			hit_q       <= 1'b0;
			hit_cnt_q   <= '0;
			atime_q     <= '0;
			miss_q      <= '0;
			cyc_q       <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_way_q   <= '0;
			out_miss_q  <= '0;
			out_cyc_q   <= '0;
		end else begin
			if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;

			if (accept) begin
				tag_q     <= tag_in;
				way_idx_q <= '0;
				hit_q     <= 1'b0;
				if (SETS_POW2) begin
					set_q <= (SETS == 1) ? '0 : idx_raw[SET_W-1:0];
				end
			end

			if (st_q == ST_MOD && mod_done) set_q <= mod_rem;

			if (st_q == ST_CMP) begin
				if (match) begin
					hit_q     <= 1'b1;
					hit_cnt_q <= rd_cnt_q;
				end else begin
					// lowest metric wins, earliest way on ties
					if (way_idx_q == '0 || metric < best_q) begin
						victim_q <= way_idx_q;
						best_q   <= metric;
					end
					if (way_idx_q != nways_last) way_idx_q <= way_idx_q + 1'b1;
				end
			end

			if (finish) begin
				atime_q     <= atime_q + 32'd1;
				miss_q      <= miss_new;
				cyc_q       <= cyc_new;
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
				out_way_q   <= way_ext[2:0];
				out_miss_q  <= miss_new;
				out_cyc_q   <= cyc_new;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------- line memories
	logic                     vld_mem [LINES];
	logic [ADDRESS_WIDTH-1:0] tag_mem [LINES];
	logic [15:0]              cnt_mem [LINES];
	logic [31:0]              tim_mem [LINES];

	always_ff @(posedge clk) begin
		if (we_vld) vld_mem[wr_addr] <= wr_vld;
		if (rd_en) rd_vld_q <= vld_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_tag) tag_mem[wr_addr] <= tag_q;
		if (rd_en) rd_tag_q <= tag_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_cnt) cnt_mem[wr_addr] <= wr_cnt;
		if (rd_en) rd_cnt_q <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we_tim) tim_mem[wr_addr] <= wr_tim;
		if (rd_en) rd_tim_q <= tim_mem[rd_addr];
	end

	// ---------------------------------------------------------- set remainder
	sacl_set_mod #(
		.SETS(SETS)
	) u_set_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.raw   (idx_raw),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign way         = out_way_q;
	assign miss_total  = out_miss_q;
	assign cycle_total = out_cyc_q;

	// ---------------------------------------------------------- checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> in_stall)
		else $error("item taken during clearing pass");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CMP) |-> (way_idx_q <= nways_last))
		else $error("way scan beyond ways in use");

	a_miss_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (miss_q >= $past(miss_q)))
		else $error("miss total decreased");

	a_cycle_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cyc_q >= $past(cyc_q)))
		else $error("cycle total decreased");

	a_finish_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && out_miss_q == miss_q && out_cyc_q == cyc_q))
		else $error("result not loaded with the updated totals");

endmodule

>>> rtl/sacl_set_mod.sv
// sacl_set_mod: raw set index modulo the set count by reciprocal multiplication,
// with index, product and remainder registered in turn from start to done. Depends on sacl_pkg.
module sacl_set_mod
	import sacl_pkg::*;
#(
	parameter int SETS = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [IDX_RAW_W-1:0]                   raw,
	output logic                                   done,
	output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] rem
);

	localparam int     SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int     SH    = IDX_RAW_W + SET_W;
	// ceil(2^SH / SETS) gives the exact quotient for every raw index
	localparam longint RECIP = ((longint'(1) << SH) + longint'(SETS) - longint'(1))
	                           / longint'(SETS);

	logic                 run_s1;
	logic                 run_s2;
	logic                 done_q;
	logic [IDX_RAW_W-1:0] raw_s1;
	logic [IDX_RAW_W-1:0] raw_s2;
	logic [31:0]          prod_s2;
	logic [SET_W-1:0]     rem_q;
	logic [IDX_RAW_W-1:0] quo;
	logic [31:0]          back;
	logic [31:0]          diff;
	logic [SET_W-1:0]     rem_d;

	always_comb begin
		quo  = IDX_RAW_W'(prod_s2 >> SH);
		back = 32'(quo) * 32'(SETS);
		diff = 32'(raw_s2) - back;
		// one correction step, never taken with an exact quotient
		if (diff >= 32'(SETS)) begin
			rem_d = SET_W'(diff - 32'(SETS));
		end else begin
			rem_d = SET_W'(diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1  <= 1'b0;
			run_s2  <= 1'b0;
			done_q  <= 1'b0;
			raw_s1  <= '0;
			raw_s2  <= '0;
			prod_s2 <= '0;
			rem_q   <= '0;
		end else begin
			run_s1 <= start;
			run_s2 <= run_s1;
			done_q <= run_s2;
			if (start) raw_s1 <= raw;
			if (run_s1) begin
				raw_s2  <= raw_s1;
				prod_s2 <= 32'(raw_s1) * 32'(RECIP);
			end
			if (run_s2) rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> test/cache_lookup_checker.sv
// cache_lookup_checker: scoreboard for set_assoc_cache_lru_lfu_lookup.
// Watches the address, result and register channels, predicts each lookup and compares.
// Depends on sacl_pkg for register indexes, policy codes and saturation limits.
module cache_lookup_checker
	import sacl_pkg::*;
#(
	parameter int SETS = 256,
	parameter int WAYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        hit,
	input  logic [2:0]  way,
	input  logic [31:0] miss_total,
	input  logic [31:0] cycle_total,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending,
	output int          lookups,
	output int          hits
);

	localparam int LINES = SETS * WAYS;

	typedef struct packed {
		logic        hit;
		logic [2:0]  way;
		logic [31:0] misses;
		logic [31:0] cycles;
	} lookup_result_t;

	// shadow copy of the cache
	logic        line_ok  [LINES];
	logic [31:0] line_tag [LINES];
	logic [15:0] use_cnt  [LINES];
	logic [31:0] stamp    [LINES];
	logic [31:0] access_clock;
	logic [31:0] misses_so_far;
	logic [31:0] cycles_so_far;

	// shadow registers
	logic        pol;
	logic [4:0]  off_bits;
	logic [3:0]  idx_bits;
	logic [3:0]  ways_cfg;
	logic [7:0]  hit_cost;
	logic [15:0] miss_cost;

	lookup_result_t expected_lookups [$];

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? TOT_MAX : s[31:0];
	endfunction

	function automatic lookup_result_t predict_lookup(input logic [31:0] a);
		logic [63:0]    wide;
		logic [31:0]    set_no;
		logic [31:0]    tag;
		logic [31:0]    metric;
		logic [31:0]    best;
		logic           found;
		int             shift;
		int             nways;
		int             base;
		int             k;
		int             victim;
		int             hit_way;
		lookup_result_t r;
		wide   = {32'd0, a};
		set_no = 32'(((wide >> off_bits) & ((64'd1 << idx_bits) - 64'd1)) % SETS);
		shift  = int'(off_bits) + int'(idx_bits);
		tag    = (shift >= 32) ? 32'd0 : 32'(wide >> shift);
		nways  = int'(ways_cfg);
		if (nways < 1) nways = 1;
		if (nways > WAYS) nways = WAYS;
		base    = int'(set_no) * WAYS;
		found   = 1'b0;
		victim  = 0;
		hit_way = 0;
		best    = '0;
		for (int i = 0; i < nways && !found; i++) begin
			k = base + i;
			if (line_ok[k] && line_tag[k] == tag) begin
				found   = 1'b1;
				hit_way = i;
				if (pol == POLICY_LFU) begin
					if (use_cnt[k] != USE_MAX) use_cnt[k] = use_cnt[k] + 16'd1;
				end else begin
					stamp[k] = access_clock;
				end
			end else begin
				metric = (pol == POLICY_LFU) ? {16'd0, use_cnt[k]} : stamp[k];
				if (i == 0 || metric < best) begin
					victim = i;
					best   = metric;
				end
			end
		end
		if (found) begin
			cycles_so_far = add_sat(cycles_so_far, {24'd0, hit_cost});
		end else begin
			k       = base + victim;
			hit_way = victim;
			cycles_so_far = add_sat(cycles_so_far, {24'd0, hit_cost} + {16'd0, miss_cost});
			misses_so_far = add_sat(misses_so_far, 32'd1);
			line_ok[k]  = 1'b1;
			line_tag[k] = tag;
			if (pol == POLICY_LFU) use_cnt[k] = 16'd1;
			else stamp[k] = access_clock;
		end
		access_clock = access_clock + 32'd1;
		r.hit    = found;
		r.way    = 3'(hit_way);
		r.misses = misses_so_far;
		r.cycles = cycles_so_far;
		return r;
	endfunction

	function automatic bit field_differs(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want === got) return 1'b0;
		$display("%0t: result %0d %s expected %0h, got %0h", $time, lookups, what, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_result_t want;
		bit             bad;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				line_ok[i]  = 1'b0;
				line_tag[i] = '0;
				use_cnt[i]  = '0;
				stamp[i]    = '0;
			end
			access_clock  = '0;
			misses_so_far = '0;
			cycles_so_far = '0;
			pol       = POLICY_LRU;
			off_bits  = 5'd4;
			idx_bits  = 4'd8;
			ways_cfg  = 4'd8;
			hit_cost  = 8'd1;
			miss_cost = 16'd100;
			expected_lookups.delete();
			fails   = 0;
			pending = 0;
			lookups = 0;
			hits    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_POLICY:       pol       = cfg_data[0];
					CFG_OFFSET_BITS:  off_bits  = cfg_data[4:0];
					CFG_INDEX_BITS:   idx_bits  = cfg_data[3:0];
					CFG_WAYS_IN_USE:  ways_cfg  = cfg_data[3:0];
					CFG_HIT_TIME:     hit_cost  = cfg_data[7:0];
					CFG_MISS_PENALTY: miss_cost = cfg_data;
					default: ;
				endcase
			end
			// results first, so an item accepted this edge never meets its own result
			if (out_valid && !out_stall) begin
				if (expected_lookups.size() == 0) begin
					$display("%0t: unexpected result, expected none, got hit %0h way %0h",
						$time, hit, way);
					fails++;
				end else begin
					want = expected_lookups.pop_front();
					bad  = 1'b0;
					if (field_differs("hit", {31'd0, want.hit}, {31'd0, hit})) bad = 1'b1;
					if (field_differs("way", {29'd0, want.way}, {29'd0, way})) bad = 1'b1;
					if (field_differs("miss_total", want.misses, miss_total)) bad = 1'b1;
					if (field_differs("cycle_total", want.cycles, cycle_total)) bad = 1'b1;
					if (bad) fails++;
				end
				lookups++;
			end
			if (in_valid && !in_stall) begin
				want = predict_lookup(address);
				expected_lookups.push_back(want);
				if (want.hit) hits++;
			end
			pending = expected_lookups.size();
		end
	end

endmodule

>>> test/tb.sv
// tb: top of the set_assoc_cache_lru_lfu_lookup testbench; drives items and registers.
// Depends on sacl_pkg, the DUT and cache_lookup_checker, which predicts and compares.
module tb;
	import sacl_pkg::*;

	localparam int SETS          = 256;
	localparam int WAYS          = 8;
	localparam int ADDRESS_WIDTH = 32;

	// longest stretch without any handshake; it has to outlast the clearing pass after reset
	localparam int IDLE_LIMIT = 20000;
	// index past the last register; writes there must be ignored
	localparam logic [2:0] CFG_SPARE = 3'd6;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 105;

	logic        clk;
	logic        arst_n;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [31:0] address   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic [2:0]  way;
	logic [31:0] miss_total;
	logic [31:0] cycle_total;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	int fails;
	int pending;
	int lookups;
	int hits;

	// percent of cycles the address side holds back / the result side stalls
	int gap_pct       = 0;
	int stall_pct     = 0;
	int settings_used = 0;
	int quiet_cycles  = 0;

	set_assoc_cache_lru_lfu_lookup #(
		.SETS         (SETS),
		.WAYS         (WAYS),
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.way        (way),
		.miss_total (miss_total),
		.cycle_total(cycle_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	cache_lookup_checker #(
		.SETS(SETS),
		.WAYS(WAYS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.way        (way),
		.miss_total (miss_total),
		.cycle_total(cycle_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fails      (fails),
		.pending    (pending),
		.lookups    (lookups),
		.hits       (hits)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result-side backpressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: any channel moving resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending);
			$display("tb NOT OK");
			$finish;
		end
	end

	// Present one address; entered and left at a falling edge. valid is only
	// lowered during a gap, so back-to-back items keep it high without a glitch.
	task automatic send_address(input logic [31:0] a);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		address  <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Hold off until every predicted result has come out. Always waits for a
	// falling edge first so valid never gets two assignments in one step.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Program every register once the block is idle. Bits above each field
	// carry junk that the block must drop.
	task automatic configure(input logic p, input logic [4:0] ob, input logic [3:0] ib,
			input logic [3:0] nw, input logic [7:0] ht, input logic [15:0] mp);
		logic [31:0] junk;
		junk = $urandom;
		drain();
		write_reg(CFG_POLICY,       {junk[14:0], p});
		write_reg(CFG_OFFSET_BITS,  {junk[26:16], ob});
		write_reg(CFG_INDEX_BITS,   {junk[11:0], ib});
		write_reg(CFG_WAYS_IN_USE,  {junk[31:20], nw});
		write_reg(CFG_HIT_TIME,     {junk[23:16], ht});
		write_reg(CFG_MISS_PENALTY, mp);
		write_reg(CFG_SPARE,        junk[15:0]);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		logic [31:0] tags [12];
		logic [7:0]  sets [3];
		logic [31:0] a;
		logic [63:0] line;
		logic        p;
		logic [4:0]  ob;
		logic [3:0]  ib;
		logic [3:0]  nw;
		logic [7:0]  ht;
		logic [15:0] mp;
		int          shift;

		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// --- directed part, reset settings first: LRU, 4/8 split, 8 ways ---
		send_address(32'h0000_0000);
		send_address(32'h0000_000F);   // same line, other offset: hit
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FFF0);
		// nine tags into set 0: the last two evict the least recently used ways
		for (int t = 1; t <= 9; t++) send_address(32'(t) << 12);
		send_address(32'h0000_2000);

		// LFU, single set, zero ways acts as one way, free accesses
		configure(POLICY_LFU, 5'd0, 4'd0, 4'd0, 8'd0, 16'd0);
		send_address(32'h5);
		send_address(32'h5);
		send_address(32'h6);

		// tag shift past the address width: every tag is zero; ways above max clamp
		configure(POLICY_LRU, 5'd31, 4'd15, 4'd15, 8'd255, 16'hFFFF);
		send_address(32'h0000_0000);
		send_address(32'h8000_0000);
		send_address(32'h7FFF_FFFF);
		send_address(32'hFFFF_FFFF);

		// 12 index bits on 256 sets: index wraps modulo the set count
		configure(POLICY_LFU, 5'd0, 4'd12, 4'd8, 8'd1, 16'd7);
		send_address(32'h0000_0100);
		send_address(32'h0000_0000);
		send_address(32'h0000_0F05);
		send_address(32'h0000_0005);

		// --- random part: working sets of a few sets and a dozen tags ---
		// Policy flips between phases keep the lines, so stale metrics get used.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 62; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 62; end
				default: begin gap_pct = 15; stall_pct = 15; end
			endcase
			if (ph == 0) begin
				p = POLICY_LFU; ob = 5'd0;  ib = 4'd8; nw = 4'd8; ht = 8'd255; mp = 16'hFFFF;
			end else if (ph == 1) begin
				p = POLICY_LRU; ob = 5'd16; ib = 4'd0; nw = 4'd1; ht = 8'd0;   mp = 16'd0;
			end else begin
				p  = 1'($urandom_range(1));
				ob = ($urandom_range(3) == 0) ? 5'($urandom_range(31, 17))
				                              : 5'($urandom_range(16));
				ib = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9))
				                              : 4'($urandom_range(8));
				nw = 4'($urandom_range(15));
				ht = 8'($urandom_range(255));
				mp = 16'($urandom_range(65535));
			end
			configure(p, ob, ib, nw, ht, mp);
			shift = int'(ob) + int'(ib);
			foreach (tags[t]) tags[t] = $urandom;
			foreach (sets[s]) sets[s] = 8'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// now and then let the pipe run dry before the next item
				if ($urandom_range(49) == 0) drain();
				if ($urandom_range(9) < 7) begin
					line = ((shift >= 32) ? 64'd0
					                      : ({32'd0, tags[$urandom_range(11)]} << shift))
					     | ({56'd0, sets[$urandom_range(2)]} << ob)
					     | ({32'd0, 32'($urandom)} & ((64'd1 << ob) - 64'd1));
					a = line[31:0];
				end else begin
					a = $urandom;
				end
				send_address(a);
			end
		end

		drain();
		repeat (40) @(negedge clk);

		if (pending != 0)
			$display("%0t: %0d expected results never came out", $time, pending);
		$display("Covered %0d lookups (%0d hits) over %0d register settings, both policies,",
			lookups, hits, settings_used);
		$display("edge field splits, all idle/stall mixes and stale metrics across policy flips.");
		if (fails == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

>>> set_assoc_cache_lru_lfu_lookup.f
rtl/sacl_pkg.sv
rtl/sacl_set_mod.sv
rtl/set_assoc_cache_lru_lfu_lookup.sv
test/cache_lookup_checker.sv
test/tb.sv
